// ===== hw/rtl/stok_pkg.sv =====
`timescale 1ns / 1ps

package stok_pkg;

    localparam int POS_BITS      = 16;
    localparam int KEYWORD_CHARS = 6;
    localparam int OUT_BITS      = 16;
    localparam int KW_WIN_W      = 8 * KEYWORD_CHARS;
    localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
    localparam int KW_COUNT      = 7;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_EQ      = 4'd2;
    localparam logic [3:0] M_BANG    = 4'd3;
    localparam logic [3:0] M_INT     = 4'd4;
    localparam logic [3:0] M_DOT     = 4'd5;
    localparam logic [3:0] M_FRAC    = 4'd6;
    localparam logic [3:0] M_IDENT   = 4'd7;
    localparam logic [3:0] M_GARB    = 4'd8;

    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_LPAREN  = 5'd1;
    localparam logic [4:0] KIND_RPAREN  = 5'd2;
    localparam logic [4:0] KIND_LBRACE  = 5'd3;
    localparam logic [4:0] KIND_RBRACE  = 5'd4;
    localparam logic [4:0] KIND_ASSIGN  = 5'd5;
    localparam logic [4:0] KIND_EQ      = 5'd6;
    localparam logic [4:0] KIND_COLON   = 5'd7;
    localparam logic [4:0] KIND_COMMA   = 5'd8;
    localparam logic [4:0] KIND_SEMI    = 5'd9;
    localparam logic [4:0] KIND_BANG    = 5'd10;
    localparam logic [4:0] KIND_NE      = 5'd11;
    localparam logic [4:0] KIND_PLUS    = 5'd12;
    localparam logic [4:0] KIND_MINUS   = 5'd13;
    localparam logic [4:0] KIND_STAR    = 5'd14;
    localparam logic [4:0] KIND_SLASH   = 5'd15;
    localparam logic [4:0] KIND_LT      = 5'd16;
    localparam logic [4:0] KIND_GT      = 5'd17;
    localparam logic [4:0] KIND_INT     = 5'd18;
    localparam logic [4:0] KIND_FLOAT   = 5'd19;
    localparam logic [4:0] KIND_GARBAGE = 5'd20;
    localparam logic [4:0] KIND_IDENT   = 5'd21;
    localparam logic [4:0] KIND_DEF     = 5'd22;

    localparam logic [7:0] CH_EOF   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_BANG  = "!";

    // keywords packed first character lowest
    localparam logic [63:0] KW_WORDS [KW_COUNT] = '{
        64'("fed"), 64'("tel"), 64'("nruter"), 64'("ro"),
        64'("dna"), 64'("eurt"), 64'("eslaf")
    };

    typedef struct packed {
        logic [4:0]          kind;
        logic [OUT_BITS-1:0] at_line;
        logic [OUT_BITS-1:0] at_col;
        logic [OUT_BITS-1:0] length;
        logic                last;
    } t_tok;

    typedef struct packed {
        logic [1:0] count;
        t_tok       tok0;
        t_tok       tok1;
    } t_push;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

    function automatic logic [OUT_BITS-1:0] clip_out(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[OUT_BITS-1:0];
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ":":     k = KIND_COLON;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "<":     k = KIND_LT;
            ">":     k = KIND_GT;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/stok_scan.sv =====
`timescale 1ns / 1ps

module stok_scan
    import stok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_ch,
    output t_push      o_push
);

    logic [3:0]          r_mode, n_mode;
    logic [POS_BITS-1:0] r_line, n_line;
    logic [POS_BITS-1:0] r_col, n_col;
    logic [POS_BITS-1:0] r_tline, n_tline;
    logic [POS_BITS-1:0] r_tcol, n_tcol;
    logic [POS_BITS-1:0] r_len, n_len;
    logic [KW_WIN_W-1:0] r_win, n_win;
    logic                r_long, n_long;

    logic                tk_emit;
    logic [4:0]          tk_kind;
    logic [POS_BITS-1:0] tk_len;
    logic                id_emit;
    logic [4:0]          id_kind;
    logic [POS_BITS-1:0] id_len;
    logic                do_idle;
    logic                cons;
    logic                grow;
    logic                start;
    logic [3:0]          start_mode;
    logic                eof_rst;
    logic [4:0]          word_k;
    logic [4:0]          sk;
    logic                ident_ch;
    logic [KW_IDX_W-1:0] kidx;
    t_tok                tok_a;
    t_tok                tok_b;

    assign sk       = single_kind(i_ch);
    assign ident_ch = is_alpha(i_ch) || is_digit(i_ch) || (i_ch == CH_UNDER);
    assign kidx     = r_len[KW_IDX_W-1:0];

    always_comb begin
        word_k = KIND_IDENT;
        if (!r_long) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (r_win == KW_WORDS[i][KW_WIN_W-1:0]) begin
                    word_k = KIND_DEF + 5'(i);
                end
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_len   = r_len;
        n_win   = r_win;
        n_long  = r_long;

        tk_emit    = 1'b0;
        tk_kind    = KIND_EOF;
        tk_len     = r_len;
        id_emit    = 1'b0;
        id_kind    = KIND_EOF;
        id_len     = POS_ONE;
        do_idle    = 1'b0;
        cons       = 1'b0;
        grow       = 1'b0;
        start      = 1'b0;
        start_mode = M_IDLE;
        eof_rst    = 1'b0;

        unique case (r_mode)
            M_COMMENT: begin
                if (i_ch == CH_EOF) begin
                    do_idle = 1'b1;
                end else begin
                    cons = 1'b1;
                    if (i_ch == CH_NL) begin
                        n_mode = M_IDLE;
                    end
                end
            end
            M_EQ, M_BANG: begin
                tk_emit = 1'b1;
                if (i_ch == CH_EQ) begin
                    tk_kind = (r_mode == M_EQ) ? KIND_EQ : KIND_NE;
                    tk_len  = POS_BITS'(2);
                    cons    = 1'b1;
                    n_mode  = M_IDLE;
                end else begin
                    tk_kind = (r_mode == M_EQ) ? KIND_ASSIGN : KIND_BANG;
                    tk_len  = POS_ONE;
                    do_idle = 1'b1;
                end
            end
            M_INT: begin
                if (is_digit(i_ch)) begin
                    grow = 1'b1;
                end else if (i_ch == CH_DOT) begin
                    grow   = 1'b1;
                    n_mode = M_DOT;
                end else begin
                    tk_emit = 1'b1;
                    tk_kind = KIND_INT;
                    do_idle = 1'b1;
                end
            end
            M_DOT: begin
                if (is_digit(i_ch)) begin
                    grow   = 1'b1;
                    n_mode = M_FRAC;
                end else begin
                    tk_emit = 1'b1;
                    tk_kind = KIND_GARBAGE;
                    do_idle = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_digit(i_ch)) begin
                    grow = 1'b1;
                end else begin
                    tk_emit = 1'b1;
                    tk_kind = KIND_FLOAT;
                    do_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (ident_ch) begin
                    if (!r_long && (r_len < POS_BITS'(KEYWORD_CHARS))) begin
                        n_win[8*kidx +: 8] = i_ch;
                    end else begin
                        n_long = 1'b1;
                    end
                    grow = 1'b1;
                end else begin
                    tk_emit = 1'b1;
                    tk_kind = word_k;
                    do_idle = 1'b1;
                end
            end
            M_GARB: begin
                if ((i_ch != CH_EOF) && !is_ws(i_ch)) begin
                    grow = 1'b1;
                end else begin
                    tk_emit = 1'b1;
                    tk_kind = KIND_GARBAGE;
                    do_idle = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            n_mode = M_IDLE;
            priority if (i_ch == CH_EOF) begin
                id_emit = 1'b1;
                id_kind = KIND_EOF;
                id_len  = '0;
                eof_rst = 1'b1;
            end else if (is_ws(i_ch)) begin
                cons = 1'b1;
            end else if (i_ch == CH_HASH) begin
                cons   = 1'b1;
                n_mode = M_COMMENT;
            end else if (sk != KIND_EOF) begin
                id_emit = 1'b1;
                id_kind = sk;
                cons    = 1'b1;
            end else if (i_ch == CH_EQ) begin
                start      = 1'b1;
                start_mode = M_EQ;
            end else if (i_ch == CH_BANG) begin
                start      = 1'b1;
                start_mode = M_BANG;
            end else if (is_digit(i_ch)) begin
                start      = 1'b1;
                start_mode = M_INT;
            end else if (is_alpha(i_ch) || (i_ch == CH_UNDER)) begin
                start      = 1'b1;
                start_mode = M_IDENT;
                n_win      = KW_WIN_W'(i_ch);
                n_long     = 1'b0;
            end else begin
                start      = 1'b1;
                start_mode = M_GARB;
            end
        end

        if (grow) begin
            n_len = sat_inc(r_len);
            cons  = 1'b1;
        end
        if (start) begin
            n_tline = r_line;
            n_tcol  = r_col;
            n_len   = POS_ONE;
            n_mode  = start_mode;
            cons    = 1'b1;
        end
        if (cons) begin
            if (i_ch == CH_NL) begin
                n_line = sat_inc(r_line);
                n_col  = POS_ONE;
            end else begin
                n_col = sat_inc(r_col);
            end
        end
        if (eof_rst) begin
            n_line = POS_ONE;
            n_col  = POS_ONE;
        end
    end

    always_comb begin
        tok_a.kind    = tk_kind;
        tok_a.at_line = clip_out(r_tline);
        tok_a.at_col  = clip_out(r_tcol);
        tok_a.length  = clip_out(tk_len);
        tok_a.last    = !id_emit;

        tok_b.kind    = id_kind;
        tok_b.at_line = clip_out(r_line);
        tok_b.at_col  = clip_out(r_col);
        tok_b.length  = clip_out(id_len);
        tok_b.last    = 1'b1;

        o_push.tok1 = tok_b;
        if (tk_emit) begin
            o_push.tok0 = tok_a;
        end else begin
            o_push.tok0 = tok_b;
        end
        if (!i_take) begin
            o_push.count = 2'd0;
        end else begin
            o_push.count = 2'(tk_emit) + 2'(id_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_tline <= '0;
            r_tcol  <= '0;
            r_len   <= '0;
            r_win   <= '0;
            r_long  <= 1'b0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_len   <= n_len;
            r_win   <= n_win;
            r_long  <= n_long;
        end
    end

endmodule

// ===== hw/rtl/stok_queue.sv =====
`timescale 1ns / 1ps

module stok_queue
    import stok_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_tok  o_tok
);

    t_tok       r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;

    assign o_valid = (r_cnt != 3'd0);
    assign o_full  = (r_cnt > 3'd2);
    assign o_tok   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + i_push.count;
        n_rp  = r_rp + 2'(i_pop);
        n_cnt = r_cnt + 3'(i_push.count) - 3'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/source_tokenizer_core.sv =====
`timescale 1ns / 1ps
// Queueing: a token enters the output queue as the byte that ends it is taken.
// Throughput: one byte per cycle while results drain; a byte can yield two
// tokens, which leave one per cycle while i_stall is low, through a four-entry
// output queue that raises o_stall once it holds three tokens.
// Reset: synchronous, active low; position returns to line 1 column 1, the
// scanner goes idle between tokens and the output queue empties.

module source_tokenizer_core
    import stok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_ch,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [4:0]          o_kind,
    output logic [OUT_BITS-1:0] o_start_line,
    output logic [OUT_BITS-1:0] o_start_col,
    output logic [OUT_BITS-1:0] o_length,
    output logic                o_last
);

    logic  full;
    logic  take;
    logic  pop;
    t_push push;
    t_tok  tok;

    assign o_stall = full;
    assign take    = i_valid && !full;
    assign pop     = o_valid && !i_stall;

    stok_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_ch    (i_ch),
        .o_push  (push)
    );

    stok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (o_valid),
        .o_tok   (tok)
    );

    assign o_kind       = tok.kind;
    assign o_start_line = tok.at_line;
    assign o_start_col  = tok.at_col;
    assign o_length     = tok.length;
    assign o_last       = tok.last;

endmodule

// ===== tb/sv/source_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps

module source_tokenizer_core_tb;
    import stok_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned RANDOM_BYTES = 1800;
    localparam int unsigned PRINT_CAP = 40;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [7:0]          i_ch = 8'h00;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [4:0]          o_kind;
    logic [OUT_BITS-1:0] o_start_line;
    logic [OUT_BITS-1:0] o_start_col;
    logic [OUT_BITS-1:0] o_length;
    logic                o_last;

    source_tokenizer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_start_line (o_start_line),
        .o_start_col  (o_start_col),
        .o_length     (o_length),
        .o_last       (o_last)
    );

    string keyword_text [7] = '{"def", "let", "return", "or", "and", "true", "false"};
    string punct_chars = "(){}:,;+-*/<>=!";

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    bit          quiet = 1'b0;

    t_tok tokens_due [$];
    t_tok step_toks [$];
    t_tok want_tok;

    logic [3:0]  scan_state = M_IDLE;
    logic [15:0] cur_line = 16'd1;
    logic [15:0] cur_col = 16'd1;
    logic [15:0] tok_line = 16'd0;
    logic [15:0] tok_col = 16'd0;
    logic [15:0] tok_len = 16'd0;
    logic [47:0] word_buf = 48'd0;
    logic        word_long = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------- token predictor ----------------

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        case (c)
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            "{": return KIND_LBRACE;
            "}": return KIND_RBRACE;
            ":": return KIND_COLON;
            ",": return KIND_COMMA;
            ";": return KIND_SEMI;
            "+": return KIND_PLUS;
            "-": return KIND_MINUS;
            "*": return KIND_STAR;
            "/": return KIND_SLASH;
            "<": return KIND_LT;
            ">": return KIND_GT;
            default: return KIND_EOF;
        endcase
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void advance_pos(input logic [7:0] c);
        if (c == CH_NL) begin
            cur_line = bump(cur_line);
            cur_col = 16'd1;
        end else begin
            cur_col = bump(cur_col);
        end
    endfunction

    function automatic void open_tok(input logic [7:0] c, input logic [3:0] st);
        tok_line = cur_line;
        tok_col = cur_col;
        tok_len = 16'd1;
        scan_state = st;
        advance_pos(c);
    endfunction

    function automatic void extend_tok(input logic [7:0] c);
        tok_len = bump(tok_len);
        advance_pos(c);
    endfunction

    function automatic void add_tok(input logic [4:0] k, input logic [15:0] ln,
                                    input logic [15:0] cl, input logic [15:0] len);
        t_tok t;
        t.kind = k;
        t.at_line = ln;
        t.at_col = cl;
        t.length = len;
        t.last = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic logic [63:0] keyword_bits(input string s);
        logic [63:0] w;
        w = 64'd0;
        for (int i = 0; i < s.len(); i++)
            w = w | (64'(s[i]) << (8 * i));
        return w;
    endfunction

    function automatic logic [4:0] word_kind_of();
        if (word_long)
            return KIND_IDENT;
        for (int i = 0; i < 7; i++)
            if (64'(word_buf) == keyword_bits(keyword_text[i]))
                return 5'(KIND_DEF + i);
        return KIND_IDENT;
    endfunction

    function automatic void start_fresh(input logic [7:0] c);
        scan_state = M_IDLE;
        if (c == CH_EOF) begin
            add_tok(KIND_EOF, cur_line, cur_col, 16'd0);
            cur_line = 16'd1;
            cur_col = 16'd1;
        end else if (is_space(c)) begin
            advance_pos(c);
        end else if (c == CH_HASH) begin
            advance_pos(c);
            scan_state = M_COMMENT;
        end else if (punct_kind(c) != KIND_EOF) begin
            add_tok(punct_kind(c), cur_line, cur_col, 16'd1);
            advance_pos(c);
        end else if (c == CH_EQ) begin
            open_tok(c, M_EQ);
        end else if (c == CH_BANG) begin
            open_tok(c, M_BANG);
        end else if (is_num(c)) begin
            open_tok(c, M_INT);
        end else if (is_letter(c) || c == CH_UNDER) begin
            open_tok(c, M_IDENT);
            word_buf = 48'(c);
            word_long = 1'b0;
        end else begin
            open_tok(c, M_GARB);
        end
    endfunction

    function automatic void predict_tokens(input logic [7:0] c);
        logic [4:0] single_k;
        logic [4:0] pair_k;
        step_toks.delete();
        single_k = (scan_state == M_EQ) ? KIND_ASSIGN : KIND_BANG;
        pair_k = (scan_state == M_EQ) ? KIND_EQ : KIND_NE;
        case (scan_state)
            M_COMMENT: begin
                if (c == CH_EOF) begin
                    start_fresh(c);
                end else begin
                    advance_pos(c);
                    if (c == CH_NL)
                        scan_state = M_IDLE;
                end
            end
            M_EQ, M_BANG: begin
                if (c == CH_EQ) begin
                    add_tok(pair_k, tok_line, tok_col, 16'd2);
                    advance_pos(c);
                    scan_state = M_IDLE;
                end else begin
                    add_tok(single_k, tok_line, tok_col, 16'd1);
                    start_fresh(c);
                end
            end
            M_INT: begin
                if (is_num(c)) begin
                    extend_tok(c);
                end else if (c == CH_DOT) begin
                    extend_tok(c);
                    scan_state = M_DOT;
                end else begin
                    add_tok(KIND_INT, tok_line, tok_col, tok_len);
                    start_fresh(c);
                end
            end
            M_DOT: begin
                if (is_num(c)) begin
                    extend_tok(c);
                    scan_state = M_FRAC;
                end else begin
                    add_tok(KIND_GARBAGE, tok_line, tok_col, tok_len);
                    start_fresh(c);
                end
            end
            M_FRAC: begin
                if (is_num(c)) begin
                    extend_tok(c);
                end else begin
                    add_tok(KIND_FLOAT, tok_line, tok_col, tok_len);
                    start_fresh(c);
                end
            end
            M_IDENT: begin
                if (is_letter(c) || is_num(c) || c == CH_UNDER) begin
                    if (!word_long && tok_len < KEYWORD_CHARS)
                        word_buf[8 * tok_len +: 8] = c;
                    else
                        word_long = 1'b1;
                    extend_tok(c);
                end else begin
                    add_tok(word_kind_of(), tok_line, tok_col, tok_len);
                    start_fresh(c);
                end
            end
            M_GARB: begin
                if (c != CH_EOF && !is_space(c)) begin
                    extend_tok(c);
                end else begin
                    add_tok(KIND_GARBAGE, tok_line, tok_col, tok_len);
                    start_fresh(c);
                end
            end
            default: start_fresh(c);
        endcase
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i])
            tokens_due.push_back(step_toks[i]);
    endfunction

    // ---------------- request side ----------------

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] ch);
        int unsigned gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_ch <= ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_tokens(ch);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    initial begin : result_stall
        int unsigned run;
        int unsigned hold;
        forever begin
            run = $urandom_range(0, 15);
            repeat (run + 1) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            hold = pick_gap();
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
        end
    end

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (tokens_due.size() == 0) begin
                report_mismatch("token with none pending, kind", 32'd0, 32'(o_kind));
            end else begin
                want_tok = tokens_due.pop_front();
                if (o_kind !== want_tok.kind)
                    report_mismatch("kind", 32'(want_tok.kind), 32'(o_kind));
                if (o_start_line !== want_tok.at_line)
                    report_mismatch("start line", 32'(want_tok.at_line),
                                    32'(o_start_line));
                if (o_start_col !== want_tok.at_col)
                    report_mismatch("start column", 32'(want_tok.at_col),
                                    32'(o_start_col));
                if (o_length !== want_tok.length)
                    report_mismatch("length", 32'(want_tok.length), 32'(o_length));
                if (o_last !== want_tok.last)
                    report_mismatch("last", 32'(want_tok.last), 32'(o_last));
            end
        end
    end

    // ---------------- random content ----------------

    function automatic logic [7:0] rand_space();
        int unsigned r;
        r = $urandom_range(0, 6);
        return (r >= 5) ? 8'(" ") : 8'(9 + r);
    endfunction

    function automatic logic [7:0] rand_word_char(input bit lead);
        int unsigned r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'(r) + "a";
        if (r < 52)
            return 8'(r - 26) + "A";
        if (r == 52)
            return CH_UNDER;
        return 8'(r - 53) + "0";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(0, 9)) + "0";
    endfunction

    function automatic logic opens_token(input logic [7:0] c);
        return is_space(c) || c == CH_HASH || punct_kind(c) != KIND_EOF || c == CH_EQ
            || c == CH_BANG || is_num(c) || is_letter(c) || c == CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_garbage_head();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(128, 255));
        c = 8'($urandom_range(1, 127));
        while (opens_token(c))
            c = 8'($urandom_range(1, 127));
        return c;
    endfunction

    function automatic logic [7:0] rand_solid_byte();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (is_space(c))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic send_random_token();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            send_text(keyword_text[$urandom_range(0, 6)]);
            if ($urandom_range(0, 3) == 0)
                send_byte(rand_word_char(1'b0));
        end else if (pick < 30) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            send_byte(rand_word_char(1'b1));
            repeat (len - 1) send_byte(rand_word_char(1'b0));
        end else if (pick < 42) begin
            repeat ($urandom_range(1, 5)) send_byte(rand_digit());
        end else if (pick < 50) begin
            repeat ($urandom_range(1, 3)) send_byte(rand_digit());
            send_byte(CH_DOT);
            repeat ($urandom_range(1, 3)) send_byte(rand_digit());
        end else if (pick < 53) begin
            repeat ($urandom_range(1, 3)) send_byte(rand_digit());
            send_byte(CH_DOT);
        end else if (pick < 68) begin
            if ($urandom_range(0, 3) == 0)
                send_text($urandom_range(0, 1) ? "==" : "!=");
            else
                send_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        end else if (pick < 74) begin
            send_byte(CH_HASH);
            repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(1, 255)));
            send_byte(($urandom_range(0, 5) == 0) ? CH_EOF : CH_NL);
        end else if (pick < 80) begin
            send_byte(rand_garbage_head());
            repeat ($urandom_range(0, 4)) send_byte(rand_solid_byte());
        end else if (pick < 83) begin
            send_byte(CH_EOF);
        end else if (pick < 90) begin
            send_byte(CH_NL);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_byte(rand_space());
        else if (pick < 75)
            repeat ($urandom_range(2, 4)) send_byte(rand_space());
    endtask

    // ---------------- tests ----------------

    task automatic test_operators();
        send_text("(){}:,;+-*/<>==!=");
        send_byte(CH_EQ);
        send_byte(CH_BANG);
        send_byte(CH_EOF);
    endtask

    task automatic test_numbers_and_bytes();
        send_text("12 3.25 7.x ");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_text("\n#c");
        send_byte(CH_EOF);
    endtask

    task automatic test_long_word();
        send_text("returns\n");
    endtask

    task automatic test_random_stream();
        int unsigned target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 24) == 0)
                quiet = ~quiet;
            send_random_token();
        end
        quiet = 1'b0;
        send_byte(CH_EOF);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_operators();
        test_numbers_and_bytes();
        test_long_word();
        test_random_stream();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && tokens_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
